// File: rtl/calendar_date_arithmetic_defines.svh
// Assertion macros for the calendar date unit.
// Used by the checker; expects clk and rst_n in the including scope.
`ifndef CALENDAR_DATE_ARITHMETIC_DEFINES_SVH
`define CALENDAR_DATE_ARITHMETIC_DEFINES_SVH

// same-cycle implication
`define CDA_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calendar date unit check failed");

// next-cycle implication
`define CDA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calendar date unit check failed");

`endif

// File: rtl/cda_pkg.sv
// Shared types, constants and calendar lookup functions for the date unit.
// No dependencies; used by cda_ctrl, cda_dp, the top level, the checker and the bench.
package cda_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFFSET_W = 22;
  localparam int DIFF_W   = 23;
  localparam int SER_W    = 22;   // serial day number 0..LAST_SERIAL
  localparam int SUM_W    = 24;   // signed working width before saturation

  localparam int LAST_SERIAL = 3652058;
  localparam int EPOCH_SHIFT = 306;       // move year start to March 1
  localparam int MAX_YEAR    = 9999;
  localparam int RECIP_100   = 5243;      // 2^19 / 100, rounded up
  localparam int RECIP_SHIFT = 19;
  localparam int ERA_DAYS    = 146097;
  localparam int CENT_DAYS   = 36524;
  localparam int YEAR_DAYS   = 365;
  localparam int LAST_DOE    = 146096;

  // reciprocal divisions, exact over the ranges that reach them
  localparam int RECIP_ERA   = 3762951;   // 2^39 / 146097, rounded up
  localparam int ERA_SHIFT   = 39;
  localparam int RECIP_365   = 183860;    // 2^26 / 365 = 2^28 / 1460, rounded up
  localparam int QUAD_SHIFT  = 28;
  localparam int YEAR_SHIFT  = 26;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_SUB     = 2'd1,
    OP_COMPARE = 2'd2,
    OP_DIFF    = 2'd3
  } cda_op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_A, ST_SUM_A, ST_MUL_B, ST_SUM_B, ST_COMPARE, ST_SHIFT,
    ST_ERA, ST_DOE, ST_QUAD, ST_ADJ, ST_YOE, ST_DOY, ST_DATE
  } cda_state_t;

  typedef enum logic [3:0] {
    DP_IDLE, DP_MUL, DP_SUM, DP_COMPARE, DP_SHIFT, DP_ERA, DP_DOE,
    DP_QUAD, DP_ADJ, DP_YOE, DP_DOY, DP_DATE
  } cda_dp_op_t;

  typedef struct packed {
    logic       load;    // latch a new item
    cda_dp_op_t op;
    logic       sel_b;   // work on the second date
  } cda_cmd_t;

  typedef struct packed {
    logic cmp_op;        // item is a compare or difference
  } cda_sts_t;

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] v;
    case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
    logic [DAY_W-1:0] v;
    case (m)
      4'd2:                      v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   v = 5'd30;
      default:                   v = 5'd31;
    endcase
    return v;
  endfunction

  // first day-of-year of each month in a March-based year
  function automatic logic [8:0] march_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic serial_out_of_range(input logic [SUM_W-1:0] s);
    return s[SUM_W-1] || (s > SUM_W'(LAST_SERIAL));
  endfunction

  function automatic logic [SER_W-1:0] serial_sat(input logic [SUM_W-1:0] s);
    logic [SER_W-1:0] v;
    if (s[SUM_W-1]) begin
      v = '0;
    end else if (s > SUM_W'(LAST_SERIAL)) begin
      v = SER_W'(LAST_SERIAL);
    end else begin
      v = s[SER_W-1:0];
    end
    return v;
  endfunction

endpackage

// File: rtl/cda_ctrl.sv
// Sequencer for the calendar date unit: walks the datapath through serial
// conversion, compare, offset and constant divisions. Depends on cda_pkg.
module cda_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output cda_pkg::cda_cmd_t   cmd,
  input  cda_pkg::cda_sts_t   sts
);

  cda_pkg::cda_state_t         state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cda_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cda_pkg::ST_IDLE:    if (start) state_nxt = cda_pkg::ST_MUL_A;
      cda_pkg::ST_MUL_A:   state_nxt = cda_pkg::ST_SUM_A;
      cda_pkg::ST_SUM_A:   state_nxt = sts.cmp_op ? cda_pkg::ST_MUL_B : cda_pkg::ST_SHIFT;
      cda_pkg::ST_MUL_B:   state_nxt = cda_pkg::ST_SUM_B;
      cda_pkg::ST_SUM_B:   state_nxt = cda_pkg::ST_COMPARE;
      cda_pkg::ST_COMPARE: state_nxt = cda_pkg::ST_IDLE;
      cda_pkg::ST_SHIFT:   state_nxt = cda_pkg::ST_ERA;
      cda_pkg::ST_ERA:     state_nxt = cda_pkg::ST_DOE;
      cda_pkg::ST_DOE:     state_nxt = cda_pkg::ST_QUAD;
      cda_pkg::ST_QUAD:    state_nxt = cda_pkg::ST_ADJ;
      cda_pkg::ST_ADJ:     state_nxt = cda_pkg::ST_YOE;
      cda_pkg::ST_YOE:     state_nxt = cda_pkg::ST_DOY;
      cda_pkg::ST_DOY:     state_nxt = cda_pkg::ST_DATE;
      cda_pkg::ST_DATE:    state_nxt = cda_pkg::ST_IDLE;
      default:             state_nxt = cda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != cda_pkg::ST_IDLE);
    cmd.load  = start && (state_r == cda_pkg::ST_IDLE);
    cmd.sel_b = 1'b0;
    cmd.op    = cda_pkg::DP_IDLE;
    case (state_r)
      cda_pkg::ST_MUL_A:    cmd.op = cda_pkg::DP_MUL;
      cda_pkg::ST_SUM_A:    cmd.op = cda_pkg::DP_SUM;
      cda_pkg::ST_MUL_B: begin
        cmd.op    = cda_pkg::DP_MUL;
        cmd.sel_b = 1'b1;
      end
      cda_pkg::ST_SUM_B: begin
        cmd.op    = cda_pkg::DP_SUM;
        cmd.sel_b = 1'b1;
      end
      cda_pkg::ST_COMPARE:  cmd.op = cda_pkg::DP_COMPARE;
      cda_pkg::ST_SHIFT:    cmd.op = cda_pkg::DP_SHIFT;
      cda_pkg::ST_ERA:      cmd.op = cda_pkg::DP_ERA;
      cda_pkg::ST_DOE:      cmd.op = cda_pkg::DP_DOE;
      cda_pkg::ST_QUAD:     cmd.op = cda_pkg::DP_QUAD;
      cda_pkg::ST_ADJ:      cmd.op = cda_pkg::DP_ADJ;
      cda_pkg::ST_YOE:      cmd.op = cda_pkg::DP_YOE;
      cda_pkg::ST_DOY:      cmd.op = cda_pkg::DP_DOY;
      cda_pkg::ST_DATE:     cmd.op = cda_pkg::DP_DATE;
      default:              cmd.op = cda_pkg::DP_IDLE;
    endcase
  end

endmodule

// File: rtl/cda_dp.sv
// Datapath of the calendar date unit: date to serial conversion, compare,
// offset, reciprocal divisions by constants, serial to date. Uses cda_pkg.
module cda_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cda_pkg::cda_cmd_t                    cmd,
  output cda_pkg::cda_sts_t                    sts,
  input  logic [1:0]                           in_operation,
  input  logic [cda_pkg::YEAR_W-1:0]           in_year,
  input  logic [cda_pkg::MONTH_W-1:0]          in_month,
  input  logic [cda_pkg::DAY_W-1:0]            in_day_of_month,
  input  logic [cda_pkg::OFFSET_W-1:0]         in_offset_days,
  input  logic [cda_pkg::YEAR_W-1:0]           in_other_year,
  input  logic [cda_pkg::MONTH_W-1:0]          in_other_month,
  input  logic [cda_pkg::DAY_W-1:0]            in_other_day,
  output logic                                 out_valid,
  output logic [cda_pkg::YEAR_W-1:0]           out_result_year,
  output logic [cda_pkg::MONTH_W-1:0]          out_result_month,
  output logic [cda_pkg::DAY_W-1:0]            out_result_day,
  output logic                                 out_less,
  output logic                                 out_equal,
  output logic signed [cda_pkg::DIFF_W-1:0]    out_difference,
  output logic                                 out_date_ok,
  output logic                                 out_overflow
);

  localparam int YW  = cda_pkg::YEAR_W;
  localparam int MW  = cda_pkg::MONTH_W;
  localparam int DW  = cda_pkg::DAY_W;
  localparam int SW  = cda_pkg::SER_W;
  localparam int UW  = cda_pkg::SUM_W;
  localparam int PW  = 26;              // reciprocal product width
  localparam int EPW = 44;              // era reciprocal product width
  localparam int QPW = 36;              // four-year and year product width

  // latched item
  cda_pkg::cda_op_t          op_r;
  logic [YW-1:0]             y1_r, y2_r;
  logic [MW-1:0]             m1_r, m2_r;
  logic [DW-1:0]             d1_r, d2_r;
  logic [cda_pkg::OFFSET_W-1:0] off_r;

  // serial conversion stage
  logic [YW-1:0]             p_r, yc_r;
  logic [6:0]                pq_r, yq_r;
  logic [SW-1:0]             p365_r;
  logic [MW-1:0]             mc_r;
  logic [DW-1:0]             dd_r;
  logic                      rng_ok_r;
  logic [SW-1:0]             s1_r, s2_r;
  logic                      ok_r, ovf_r;

  // date recovery
  logic [SW-1:0]             z_r;
  logic [4:0]                era_r;
  logic [17:0]               doe_r, adj_r;
  logic [6:0]                quad_r;
  logic [2:0]                cent_r;
  logic [8:0]                yoe_r, doy_r;

  // result registers
  logic                      valid_r;
  logic [YW-1:0]             res_year_r;
  logic [MW-1:0]             res_month_r;
  logic [DW-1:0]             res_day_r;
  logic                      res_less_r, res_equal_r, res_ok_r, res_ovf_r;
  logic [cda_pkg::DIFF_W-1:0] res_diff_r;

  // ---- clamp and reciprocal products for the selected date
  logic [YW-1:0]  ys, yc_c, p_c;
  logic [MW-1:0]  ms, mc_c;
  logic [DW-1:0]  ds;
  logic           y_lo, y_hi, m_bad;
  logic [PW-1:0]  pq_prod, yq_prod;

  always_comb begin
    ys    = cmd.sel_b ? y2_r : y1_r;
    ms    = cmd.sel_b ? m2_r : m1_r;
    ds    = cmd.sel_b ? d2_r : d1_r;
    y_lo  = (ys == '0);
    y_hi  = (ys > YW'(cda_pkg::MAX_YEAR));
    m_bad = (ms == '0) || (ms > MW'(12));
    yc_c  = y_lo ? YW'(1) : (y_hi ? YW'(cda_pkg::MAX_YEAR) : ys);
    mc_c  = (ms == '0) ? MW'(1) : ((ms > MW'(12)) ? MW'(12) : ms);
    p_c   = yc_c - 1'b1;
    pq_prod = PW'(p_c) * PW'(cda_pkg::RECIP_100);
    yq_prod = PW'(yc_c) * PW'(cda_pkg::RECIP_100);
  end

  // ---- serial sum, leap year and validity
  logic [YW-1:0]  y_rem;
  logic           leap;
  logic [UW-1:0]  s_sum;
  logic           ok_c;

  always_comb begin
    y_rem = yc_r - YW'(yq_r) * YW'(100);
    leap  = ((yc_r[1:0] == 2'b00) && (y_rem != '0)) ||
            ((y_rem == '0) && (yq_r[1:0] == 2'b00));
    s_sum = UW'(p365_r) + UW'(p_r[YW-1:2]) - UW'(pq_r) + UW'(pq_r[6:2])
          + UW'(cda_pkg::days_before(mc_r)) + UW'(leap && (mc_r > MW'(2)))
          + UW'(dd_r) - UW'(1);
    ok_c  = rng_ok_r && (dd_r != '0) && (dd_r <= cda_pkg::month_length(mc_r, leap));
  end

  // ---- offset
  logic [UW-1:0]  r_sum;
  logic [SW-1:0]  r_sat;

  always_comb begin
    if (op_r == cda_pkg::OP_ADD) r_sum = UW'(s1_r) + UW'(off_r);
    else                         r_sum = UW'(s1_r) - UW'(off_r);
    r_sat = cda_pkg::serial_sat(r_sum);
  end

  // ---- constant divisions and date recovery
  logic [EPW-1:0] era_prod;
  logic [QPW-1:0] quad_prod, yoe_prod;
  logic [2:0]     cent_c;
  logic [1:0]     yoe_cent;
  logic [17:0]    yoe_days;
  logic [3:0]     mp;
  logic [MW-1:0]  month_c;

  always_comb begin
    era_prod  = EPW'(z_r) * EPW'(cda_pkg::RECIP_ERA);
    quad_prod = QPW'(doe_r) * QPW'(cda_pkg::RECIP_365);
    yoe_prod  = QPW'(adj_r) * QPW'(cda_pkg::RECIP_365);
    // centuries in the era: at most four, so a compare per boundary
    cent_c    = 3'(doe_r >= 18'(cda_pkg::CENT_DAYS))
              + 3'(doe_r >= 18'(2 * cda_pkg::CENT_DAYS))
              + 3'(doe_r >= 18'(3 * cda_pkg::CENT_DAYS))
              + 3'(doe_r >= 18'(cda_pkg::LAST_DOE));
    if (yoe_r >= 9'd300)      yoe_cent = 2'd3;
    else if (yoe_r >= 9'd200) yoe_cent = 2'd2;
    else if (yoe_r >= 9'd100) yoe_cent = 2'd1;
    else                      yoe_cent = 2'd0;
    yoe_days = 18'(yoe_r) * 18'(cda_pkg::YEAR_DAYS) + 18'(yoe_r[8:2]) - 18'(yoe_cent);
    mp = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (doy_r >= cda_pkg::march_start(4'(k))) mp = 4'(k);
    end
    month_c = (mp < 4'd10) ? MW'(mp + 4'd3) : MW'(mp - 4'd9);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= cda_pkg::cda_op_t'(in_operation);
      y1_r  <= in_year;
      m1_r  <= in_month;
      d1_r  <= in_day_of_month;
      off_r <= in_offset_days;
      y2_r  <= in_other_year;
      m2_r  <= in_other_month;
      d2_r  <= in_other_day;
      ovf_r <= 1'b0;
    end
    case (cmd.op)
      cda_pkg::DP_MUL: begin
        p_r      <= p_c;
        yc_r     <= yc_c;
        mc_r     <= mc_c;
        dd_r     <= ds;
        pq_r     <= pq_prod[cda_pkg::RECIP_SHIFT +: 7];
        yq_r     <= yq_prod[cda_pkg::RECIP_SHIFT +: 7];
        p365_r   <= SW'(p_c) * SW'(cda_pkg::YEAR_DAYS);
        rng_ok_r <= !y_lo && !y_hi && !m_bad;
      end
      cda_pkg::DP_SUM: begin
        if (cmd.sel_b) s2_r <= cda_pkg::serial_sat(s_sum);
        else           s1_r <= cda_pkg::serial_sat(s_sum);
        ok_r  <= cmd.sel_b ? (ok_r && ok_c) : ok_c;
        ovf_r <= ovf_r || cda_pkg::serial_out_of_range(s_sum);
      end
      cda_pkg::DP_COMPARE: begin
        res_year_r  <= '0;
        res_month_r <= '0;
        res_day_r   <= '0;
        res_less_r  <= (s1_r < s2_r);
        res_equal_r <= (s1_r == s2_r);
        res_diff_r  <= cda_pkg::DIFF_W'(s1_r) - cda_pkg::DIFF_W'(s2_r);
        res_ok_r    <= ok_r;
        res_ovf_r   <= ovf_r;
      end
      cda_pkg::DP_SHIFT: begin
        ovf_r <= ovf_r || cda_pkg::serial_out_of_range(r_sum);
        z_r   <= r_sat + SW'(cda_pkg::EPOCH_SHIFT);
      end
      cda_pkg::DP_ERA: begin
        era_r <= era_prod[cda_pkg::ERA_SHIFT +: 5];
      end
      cda_pkg::DP_DOE: begin
        doe_r <= 18'(z_r - SW'(era_r) * SW'(cda_pkg::ERA_DAYS));
      end
      cda_pkg::DP_QUAD: begin
        quad_r <= quad_prod[cda_pkg::QUAD_SHIFT +: 7];
        cent_r <= cent_c;
      end
      cda_pkg::DP_ADJ: begin
        adj_r <= doe_r - 18'(quad_r) + 18'(cent_r)
               - 18'(doe_r == 18'(cda_pkg::LAST_DOE));
      end
      cda_pkg::DP_YOE: begin
        yoe_r <= yoe_prod[cda_pkg::YEAR_SHIFT +: 9];
      end
      cda_pkg::DP_DOY: begin
        doy_r <= 9'(doe_r - yoe_days);
      end
      cda_pkg::DP_DATE: begin
        res_year_r  <= YW'(yoe_r) + YW'(era_r) * YW'(400) + YW'(mp >= 4'd10);
        res_month_r <= month_c;
        res_day_r   <= DW'(doy_r - cda_pkg::march_start(mp) + 9'd1);
        res_less_r  <= 1'b0;
        res_equal_r <= 1'b0;
        res_diff_r  <= '0;
        res_ok_r    <= ok_r;
        res_ovf_r   <= ovf_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= (cmd.op == cda_pkg::DP_COMPARE) || (cmd.op == cda_pkg::DP_DATE);
    end
  end

  assign sts.cmp_op       = op_r[1];
  assign out_valid        = valid_r;
  assign out_result_year  = res_year_r;
  assign out_result_month = res_month_r;
  assign out_result_day   = res_day_r;
  assign out_less         = res_less_r;
  assign out_equal        = res_equal_r;
  assign out_difference   = res_diff_r;
  assign out_date_ok      = res_ok_r;
  assign out_overflow     = res_ovf_r;

endmodule

// File: rtl/calendar_date_arithmetic.sv
// Gregorian date unit: add/subtract days, compare, day difference.
// Instantiates cda_ctrl and cda_dp; types and constants from cda_pkg.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. busy
//   stays high while the item is worked on and drops in the cycle that
//   shows its result.
//   Each item gives exactly one result on the out_ ports, marked by
//   out_valid for one cycle. The receiver cannot stall the unit.
//   Work from accept edge to out_valid:
//     compare / difference:  two date-to-serial conversions
//     add / subtract days:  2 date-to-serial, 1 offset and
//                           7 serial-to-date steps (reciprocal divisions)
//   A new item may be started in the same cycle its predecessor's result
//   is shown.
//   Reset (synchronous, rst_n low) returns the sequencer to idle and drops
//   out_valid; the unit holds no other state between items.
module calendar_date_arithmetic (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_operation,
  input  logic [cda_pkg::YEAR_W-1:0]           in_year,
  input  logic [cda_pkg::MONTH_W-1:0]          in_month,
  input  logic [cda_pkg::DAY_W-1:0]            in_day_of_month,
  input  logic [cda_pkg::OFFSET_W-1:0]         in_offset_days,
  input  logic [cda_pkg::YEAR_W-1:0]           in_other_year,
  input  logic [cda_pkg::MONTH_W-1:0]          in_other_month,
  input  logic [cda_pkg::DAY_W-1:0]            in_other_day,
  output logic                                 out_valid,
  output logic [cda_pkg::YEAR_W-1:0]           out_result_year,
  output logic [cda_pkg::MONTH_W-1:0]          out_result_month,
  output logic [cda_pkg::DAY_W-1:0]            out_result_day,
  output logic                                 out_less,
  output logic                                 out_equal,
  output logic signed [cda_pkg::DIFF_W-1:0]    out_difference,
  output logic                                 out_date_ok,
  output logic                                 out_overflow
);

  cda_pkg::cda_cmd_t cmd;
  cda_pkg::cda_sts_t sts;

  cda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  cda_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_year          (in_year),
    .in_month         (in_month),
    .in_day_of_month  (in_day_of_month),
    .in_offset_days   (in_offset_days),
    .in_other_year    (in_other_year),
    .in_other_month   (in_other_month),
    .in_other_day     (in_other_day),
    .out_valid        (out_valid),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_less         (out_less),
    .out_equal        (out_equal),
    .out_difference   (out_difference),
    .out_date_ok      (out_date_ok),
    .out_overflow     (out_overflow)
  );

endmodule

// File: rtl/cda_checker.sv
// Port-level checks for the calendar date unit, bound to the top level.
// Depends on calendar_date_arithmetic_defines.svh and cda_pkg.
`include "calendar_date_arithmetic_defines.svh"

module cda_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic                              out_less,
  input logic                              out_equal,
  input logic signed [cda_pkg::DIFF_W-1:0] out_difference
);

  // an accepted item sets busy
  `CDA_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)

  // the result shows up as the unit goes idle
  `CDA_ASSERT_NOW(a_idle_with_result, out_valid, !busy)

  // one item, one strobe
  `CDA_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

  `CDA_ASSERT_NOW(a_less_not_equal, out_valid, !(out_less && out_equal))

  `CDA_ASSERT_NOW(a_equal_zero_diff, out_valid && out_equal, out_difference == '0)

endmodule

bind calendar_date_arithmetic cda_checker u_cda_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_less       (out_less),
  .out_equal      (out_equal),
  .out_difference (out_difference)
);

// File: bench/calendar_date_arithmetic_tb.sv
// Self-checking bench for calendar_date_arithmetic: directed edge dates, then random items.
// Expected results come from an in-bench calendar predictor; needs cda_pkg and the RTL only.
module calendar_date_arithmetic_tb;
  import cda_pkg::*;

  localparam int RANDOM_ITEMS = 1380;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 40;

  typedef struct packed {
    logic [YEAR_W-1:0]  y;
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   d;
  } ymd_t;

  typedef struct packed {
    cda_op_t               op;
    ymd_t                  first;
    logic [OFFSET_W-1:0]   offset;
    ymd_t                  second;
    bit                    hold;    // wait for all results before sending
  } date_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               less;
    logic               equal;
    logic [DIFF_W-1:0]  difference;
    logic               date_ok;
    logic               overflow;
  } date_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0]          in_operation = '0;
  logic [YEAR_W-1:0]   in_year = '0;
  logic [MONTH_W-1:0]  in_month = '0;
  logic [DAY_W-1:0]    in_day_of_month = '0;
  logic [OFFSET_W-1:0] in_offset_days = '0;
  logic [YEAR_W-1:0]   in_other_year = '0;
  logic [MONTH_W-1:0]  in_other_month = '0;
  logic [DAY_W-1:0]    in_other_day = '0;

  logic                      busy;
  logic                      out_valid;
  logic [YEAR_W-1:0]         out_result_year;
  logic [MONTH_W-1:0]        out_result_month;
  logic [DAY_W-1:0]          out_result_day;
  logic                      out_less;
  logic                      out_equal;
  logic signed [DIFF_W-1:0]  out_difference;
  logic                      out_date_ok;
  logic                      out_overflow;

  calendar_date_arithmetic uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_year(in_year), .in_month(in_month),
    .in_day_of_month(in_day_of_month), .in_offset_days(in_offset_days),
    .in_other_year(in_other_year), .in_other_month(in_other_month),
    .in_other_day(in_other_day),
    .out_valid(out_valid), .out_result_year(out_result_year),
    .out_result_month(out_result_month), .out_result_day(out_result_day),
    .out_less(out_less), .out_equal(out_equal), .out_difference(out_difference),
    .out_date_ok(out_date_ok), .out_overflow(out_overflow)
  );

  date_item_t   pending_items[$];
  date_result_t date_results_due[$];
  date_item_t   on_deck;
  date_item_t   nxt;
  date_result_t want;
  int  fail_count = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  idle_cycles = 0;
  bit  drained;

  // ---------------- calendar predictor ----------------

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic longint month_days(longint y, longint m);
    longint n;
    case (m)
      2:             n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic bit date_valid(ymd_t dt);
    if (dt.y < 1 || dt.y > MAX_YEAR || dt.m < 1 || dt.m > 12 || dt.d < 1)
      return 1'b0;
    return longint'(dt.d) <= month_days(dt.y, dt.m);
  endfunction

  // year and month clamped, day counts on freely (may leave the range)
  function automatic longint serial_of(ymd_t dt);
    longint y, m, p, acc;
    y = dt.y;
    m = dt.m;
    if (y < 1) y = 1;
    if (y > MAX_YEAR) y = MAX_YEAR;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    p = y - 1;
    acc = p * 365 + p / 4 - p / 100 + p / 400;
    for (longint k = 1; k < m; k++)
      acc += month_days(y, k);
    return acc + longint'(dt.d) - 1;
  endfunction

  function automatic longint clamp_serial(longint s);
    if (s < 0) return 0;
    if (s > LAST_SERIAL) return LAST_SERIAL;
    return s;
  endfunction

  // March-based era split; s is already within 0..LAST_SERIAL
  function automatic ymd_t ymd_of(longint s);
    longint z, era, doe, yoe, y, doy, mp, d, m;
    ymd_t dt;
    z   = s + 306;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    y   = yoe + era * 400;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    if (m <= 2) y += 1;
    dt.y = YEAR_W'(y);
    dt.m = MONTH_W'(m);
    dt.d = DAY_W'(d);
    return dt;
  endfunction

  function automatic date_result_t compute_date_result(date_item_t it);
    date_result_t r;
    longint s1, s2, sh;
    bit ovf;
    ymd_t dt;
    r  = '0;
    s1 = serial_of(it.first);
    ovf = (s1 < 0) || (s1 > LAST_SERIAL);
    s1 = clamp_serial(s1);
    if (it.op == OP_ADD || it.op == OP_SUB) begin
      sh = (it.op == OP_ADD) ? s1 + longint'(it.offset) : s1 - longint'(it.offset);
      if (sh < 0 || sh > LAST_SERIAL) ovf = 1'b1;
      dt = ymd_of(clamp_serial(sh));
      r.year    = dt.y;
      r.month   = dt.m;
      r.day     = dt.d;
      r.date_ok = date_valid(it.first);
    end else begin
      s2 = serial_of(it.second);
      if (s2 < 0 || s2 > LAST_SERIAL) ovf = 1'b1;
      s2 = clamp_serial(s2);
      r.less       = (s1 < s2);
      r.equal      = (s1 == s2);
      r.difference = DIFF_W'(s1 - s2);
      r.date_ok    = date_valid(it.first) && date_valid(it.second);
    end
    r.overflow = ovf;
    return r;
  endfunction

  // ---------------- stimulus ----------------

  task automatic add_item(cda_op_t op, int y, int m, int d, int off,
                          int y2, int m2, int d2, bit hold);
    date_item_t it;
    it.op     = op;
    it.first  = '{y: YEAR_W'(y), m: MONTH_W'(m), d: DAY_W'(d)};
    it.offset = OFFSET_W'(off);
    it.second = '{y: YEAR_W'(y2), m: MONTH_W'(m2), d: DAY_W'(d2)};
    it.hold   = hold;
    pending_items.push_back(it);
  endtask

  task automatic pick_date(output ymd_t dt);
    int k;
    k = $urandom_range(0, 99);
    if (k < 75) begin
      if (k < 10)
        dt.y = $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(9997, MAX_YEAR);
      else
        dt.y = $urandom_range(1, MAX_YEAR);
      dt.m = $urandom_range(1, 12);
      dt.d = $urandom_range(1, month_days(dt.y, dt.m));
    end else if (k < 90) begin
      // sane year and month, any day: day zero and days past month end
      dt.y = $urandom_range(1, MAX_YEAR);
      dt.m = $urandom_range(1, 12);
      dt.d = $urandom;
    end else begin
      dt.y = $urandom;
      dt.m = $urandom;
      dt.d = $urandom;
    end
  endtask

  task automatic add_random_item(bit hold);
    date_item_t it;
    int k;
    it.op = cda_op_t'($urandom_range(0, 3));
    pick_date(it.first);
    k = $urandom_range(0, 99);
    if (k < 30)      it.offset = $urandom_range(0, 366);
    else if (k < 55) it.offset = $urandom_range(0, 50000);
    else if (k < 85) it.offset = $urandom_range(0, LAST_SERIAL);
    else             it.offset = $urandom;
    k = $urandom_range(0, 99);
    if (it.op == OP_COMPARE || it.op == OP_DIFF) begin
      if (k < 15) begin
        it.second = it.first;
      end else if (k < 30) begin
        it.second   = it.first;
        it.second.d = $urandom_range(1, 31);
      end else begin
        pick_date(it.second);
      end
    end else begin
      it.second.y = $urandom;
      it.second.m = $urandom;
      it.second.d = $urandom;
    end
    it.hold = hold;
    pending_items.push_back(it);
  endtask

  // ---------------- clock, reset, sequence ----------------

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    add_item(OP_ADD, 1, 1, 1, 0, 1, 1, 1, 0);
    add_item(OP_SUB, 1, 1, 1, 1, 1, 1, 1, 0);                       // below first day
    add_item(OP_ADD, 9999, 12, 31, 1, 1, 1, 1, 0);                  // past last day
    add_item(OP_ADD, 1, 1, 1, LAST_SERIAL, 1, 1, 1, 0);
    add_item(OP_ADD, 1, 1, 1, 22'h3FFFFF, 1, 1, 1, 0);
    add_item(OP_SUB, 9999, 12, 31, LAST_SERIAL, 1, 1, 1, 0);
    add_item(OP_SUB, 9999, 12, 31, 22'h3FFFFF, 14'h3FFF, 4'hF, 5'h1F, 0);
    add_item(OP_ADD, 2000, 2, 29, 365, 1, 1, 1, 0);
    add_item(OP_ADD, 1900, 2, 29, 0, 1, 1, 1, 0);                   // not a leap year
    add_item(OP_SUB, 2024, 3, 0, 0, 1, 1, 1, 0);                    // day zero
    add_item(OP_ADD, 2023, 4, 31, 0, 1, 1, 1, 0);                   // day past month end
    add_item(OP_ADD, 0, 0, 0, 10, 0, 0, 0, 0);                      // clamp low, then underflow
    add_item(OP_SUB, 14'h3FFF, 4'hF, 31, 0, 1, 1, 1, 0);            // clamp high, lands on last day
    add_item(OP_ADD, 2100, 2, 28, 1, 1, 1, 1, 0);
    add_item(OP_COMPARE, 2024, 2, 29, 0, 2024, 2, 29, 0);
    add_item(OP_COMPARE, 2024, 2, 28, 0, 2024, 2, 29, 0);
    add_item(OP_DIFF, 1, 1, 1, 0, 9999, 12, 31, 0);                 // most negative
    add_item(OP_DIFF, 9999, 12, 31, 0, 1, 1, 1, 0);                 // most positive
    add_item(OP_COMPARE, 2023, 2, 29, 0, 2023, 3, 1, 0);            // invalid, same day
    add_item(OP_DIFF, 0, 0, 0, 0, 14'h3FFF, 4'hF, 31, 0);           // both clamp, first saturates low
    add_item(OP_COMPARE, 1600, 12, 31, 0, 1601, 1, 1, 1);
    add_item(OP_DIFF, 2024, 13, 5, 0, 2024, 12, 5, 0);              // month clamp
    for (int n = 0; n < RANDOM_ITEMS; n++)
      add_random_item(n % 250 == 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || start || date_results_due.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("calendar_date_arithmetic regression: pass");
    else
      $display("calendar_date_arithmetic regression: fail");
    $finish;
  end

  // ---------------- driver ----------------

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      // the result shown this cycle counts as arrived, whichever block runs first
      drained = (date_results_due.size() == 0) ||
                (date_results_due.size() == 1 && out_valid);
      if (start && !busy) begin
        date_results_due.push_back(compute_date_result(on_deck));
        drained = 1'b0;
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() == 0 || (pending_items[0].hold && !drained)) begin
          start <= 1'b0;
        end else begin
          nxt = pending_items.pop_front();
          on_deck         <= nxt;
          in_operation    <= nxt.op;
          in_year         <= nxt.first.y;
          in_month        <= nxt.first.m;
          in_day_of_month <= nxt.first.d;
          in_offset_days  <= nxt.offset;
          in_other_year   <= nxt.second.y;
          in_other_month  <= nxt.second.m;
          in_other_day    <= nxt.second.d;
          start           <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------- monitor ----------------

  task automatic check_field(string what, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      $display("%0t %s mismatch: expected %0d, got %0d", $time, what, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (date_results_due.size() == 0) begin
        $display("%0t unexpected item on result port: expected none, got year %0d",
                 $time, out_result_year);
        fail_count++;
      end else begin
        want = date_results_due.pop_front();
        check_field("result_year", want.year, out_result_year);
        check_field("result_month", want.month, out_result_month);
        check_field("result_day", want.day, out_result_day);
        check_field("less", want.less, out_less);
        check_field("equal", want.equal, out_equal);
        check_field("difference", $signed(want.difference), $signed(out_difference));
        check_field("date_ok", want.date_ok, out_date_ok);
        check_field("overflow", want.overflow, out_overflow);
      end
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t no item moved for %0d cycles", $time, IDLE_LIMIT);
        $display("calendar_date_arithmetic regression: fail");
        $finish;
      end
    end
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cda_pkg.sv
rtl/cda_ctrl.sv
rtl/cda_dp.sv
rtl/calendar_date_arithmetic.sv
rtl/cda_checker.sv
bench/calendar_date_arithmetic_tb.sv
